/* rtl/rcwe_pkg.sv */
`timescale 1ns / 1ps

package rcwe_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned SIZE_W  = 6;
   localparam int unsigned INDEX_W = 3;

   typedef enum logic [INDEX_W-1:0] {
      CSR_POLYNOMIAL    = 3'd0,
      CSR_CRC_ORDER     = 3'd1,
      CSR_WORD_WIDTH    = 3'd2,
      CSR_PRELOAD_ONES  = 3'd3,
      CSR_INVERT_RESULT = 3'd4
   } csr_index_type;

   localparam logic [DATA_W-1:0] POLYNOMIAL_RESET    = 32'h0000_0331;
   localparam logic [SIZE_W-1:0] CRC_ORDER_RESET     = 6'd10;
   localparam logic [SIZE_W-1:0] WORD_WIDTH_RESET    = 6'd10;
   localparam logic              PRELOAD_ONES_RESET  = 1'b1;
   localparam logic              INVERT_RESULT_RESET = 1'b1;

   // settings the update network needs
   typedef struct packed {
      logic [DATA_W-1:0] polynomial;
      logic [SIZE_W-1:0] word_width;
   } update_cfg_type;

endpackage

/* rtl/rcwe_update.sv */
`timescale 1ns / 1ps

module rcwe_update #(
   parameter int unsigned REG_W = 32
) (
   input  rcwe_pkg::update_cfg_type     cfg,
   input  logic [REG_W-1:0]             crc_start,
   input  logic [rcwe_pkg::DATA_W-1:0]  data_word,
   output logic [REG_W-1:0]             crc_next
);
   import rcwe_pkg::*;

   // unrolled LSB-first shift; data bits at or above the word width are skipped
   always_comb begin
      logic [REG_W-1:0] c;
      logic             fb;
      c  = crc_start;
      fb = 1'b0;
      for (int i = 0; i < DATA_W; i++) begin
         if (SIZE_W'(i) < cfg.word_width) begin
            fb = c[0] ^ data_word[i];
            c  = c >> 1;
            if (fb) begin
               c = c ^ cfg.polynomial[REG_W-1:0];
            end
         end
      end
      crc_next = c;
   end

endmodule

/* rtl/reflected_crc_word_engine.sv */
`timescale 1ns / 1ps
// An accepted word is registered in the input stage; a last word's CRC is then
// registered in the result stage for rsp_. Throughput: one word per cycle but for
// stalls; the unrolled shift network on the CRC register sets the cycle time.
// Stalls: a last word waits in the input stage while an earlier result is stalled.
// Reset (synchronous, active high): empties both stages, clears the CRC
// register and restores every configuration register to its default.
module reflected_crc_word_engine #(
   parameter int unsigned CRC_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rcwe_pkg::DATA_W-1:0]       req_data_word,
   input  logic                              req_first_word,
   input  logic                              req_last_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rcwe_pkg::DATA_W-1:0]       rsp_crc_value,
   input  logic                              csr_wen,
   input  logic [rcwe_pkg::INDEX_W-1:0]      csr_index,
   input  logic [rcwe_pkg::DATA_W-1:0]       csr_wdata
);
   import rcwe_pkg::*;

   localparam int unsigned REG_W = (CRC_BITS > 32) ? 32 : CRC_BITS;

   // configuration
   logic [DATA_W-1:0] poly_ff, poly_in;
   logic [SIZE_W-1:0] order_ff, order_in;
   logic [SIZE_W-1:0] width_ff, width_in;
   logic              preload_ones_ff, preload_ones_in;
   logic              invert_ff, invert_in;

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   logic [DATA_W-1:0] s1_data_ff, s1_data_in;
   logic              s1_first_ff, s1_first_in;
   logic              s1_last_ff, s1_last_in;

   // CRC state and result stage
   logic [REG_W-1:0]  crc_ff, crc_in;
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_crc_ff, out_crc_in;

   logic              req_xfer, rsp_xfer, s1_adv;
   logic [DATA_W-1:0] order_mask;
   logic [REG_W-1:0]  crc_start, crc_next, crc_final;
   update_cfg_type    upd_cfg;

   always_comb begin
      poly_in         = poly_ff;
      order_in        = order_ff;
      width_in        = width_ff;
      preload_ones_in = preload_ones_ff;
      invert_in       = invert_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_POLYNOMIAL:    poly_in         = csr_wdata;
            CSR_CRC_ORDER:     order_in        = csr_wdata[SIZE_W-1:0];
            CSR_WORD_WIDTH:    width_in        = csr_wdata[SIZE_W-1:0];
            CSR_PRELOAD_ONES:  preload_ones_in = csr_wdata[0];
            CSR_INVERT_RESULT: invert_in       = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int j = 0; j < DATA_W; j++) begin
         order_mask[j] = (SIZE_W'(j) < order_ff);
      end
   end

   // a last word may not leave the input stage while a stalled result is still held
   assign rsp_xfer  = out_valid_ff && !rsp_stall;
   assign s1_adv    = s1_valid_ff && !(s1_last_ff && out_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      s1_first_in = s1_first_ff;
      s1_last_in  = s1_last_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data_word;
         s1_first_in = req_first_word;
         s1_last_in  = req_last_word;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   assign crc_start = s1_first_ff ? (preload_ones_ff ? order_mask[REG_W-1:0] : '0) : crc_ff;
   assign upd_cfg   = '{polynomial: poly_ff, word_width: width_ff};

   rcwe_update #(
      .REG_W(REG_W)
   ) u_update (
      .cfg       (upd_cfg),
      .crc_start (crc_start),
      .data_word (s1_data_ff),
      .crc_next  (crc_next)
   );

   assign crc_final = (invert_ff ? ~crc_next : crc_next) & order_mask[REG_W-1:0];

   always_comb begin
      crc_in       = s1_adv ? crc_next : crc_ff;
      out_valid_in = out_valid_ff;
      out_crc_in   = out_crc_ff;
      if (s1_adv && s1_last_ff) begin
         out_valid_in = 1'b1;
         out_crc_in   = DATA_W'(crc_final);
      end else if (rsp_xfer) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff         <= POLYNOMIAL_RESET;
         order_ff        <= CRC_ORDER_RESET;
         width_ff        <= WORD_WIDTH_RESET;
         preload_ones_ff <= PRELOAD_ONES_RESET;
         invert_ff       <= INVERT_RESULT_RESET;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         crc_ff          <= '0;
      end else begin
         poly_ff         <= poly_in;
         order_ff        <= order_in;
         width_ff        <= width_in;
         preload_ones_ff <= preload_ones_in;
         invert_ff       <= invert_in;
         s1_valid_ff     <= s1_valid_in;
         out_valid_ff    <= out_valid_in;
         crc_ff          <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      s1_first_ff <= s1_first_in;
      s1_last_ff  <= s1_last_in;
      out_crc_ff  <= out_crc_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_crc_value = out_crc_ff;

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted word did not reach the input stage");

   a_last_blocked: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff && out_valid_ff && rsp_stall |-> req_stall)
      else $error("last word advanced over a held result");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result appeared without a last word");

   a_crc_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |=> $stable(crc_ff))
      else $error("CRC register changed with no word in the stage");

endmodule
